@@ sv/heightmap_bilinear_sampler_defines.svh @@
// Assertion macros shared by the heightmap bilinear sampler RTL.
// Standalone header: no dependencies.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hbs_pkg.sv @@
// Shared types and constants of the heightmap bilinear sampler.
// No dependencies; used by every module of the block.
`default_nettype none

package hbs_pkg;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

    // Grid indices are carried at the width of the largest grid (128 points).
    localparam int IDX_W  = 7;
    localparam int FRAC_W = 17;
    localparam int HGT_W  = 32;

    // Configuration register indexes (byte address 4*index)
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z     = 3'd1;
    localparam logic [2:0] REG_CHUNK_EXTENT = 3'd2;
    localparam logic [2:0] REG_INV_SPACING  = 3'd3;
    localparam logic [2:0] REG_GRID_SIZE    = 3'd4;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_z;
        logic [30:0] chunk_extent;
        logic [23:0] inv_spacing;
        logic [6:0]  grid_size;
    } hbs_cfg_t;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  x0;
        logic [IDX_W-1:0]  x1;
        logic [IDX_W-1:0]  z0;
        logic [IDX_W-1:0]  z1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fz;
        logic [HGT_W-1:0]  wdata;
        logic              in_chunk;
        logic              status;
    } hbs_cmd_t;

endpackage

`default_nettype wire

@@ sv/hbs_front.sv @@
// Front end: accepts requests, maps world positions onto the grid.
// Depends on hbs_pkg; feeds hbs_queue.
`default_nettype none

module hbs_front #(
    parameter int MAX_RES = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hbs_pkg::hbs_cfg_t          cfg,
    input  wire logic                       clearing,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [hbs_pkg::KIND_W-1:0] in_kind,
    input  wire logic [7:0]                 in_gx,
    input  wire logic [7:0]                 in_gz,
    input  wire logic [31:0]                in_hin,
    input  wire logic [31:0]                in_wx,
    input  wire logic [31:0]                in_wz,
    input  wire logic                       q_full,
    output logic                            q_push,
    output hbs_pkg::hbs_cmd_t               q_cmd
);

    localparam int IW = hbs_pkg::IDX_W;
    localparam int FW = hbs_pkg::FRAC_W;
    localparam int NW = IW + 1;
    localparam logic [NW-1:0] MAX_N   = NW'(MAX_RES);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_RES - 1);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MX   = 3'd1;
    localparam logic [2:0] F_MZ   = 3'd2;
    localparam logic [2:0] F_PX   = 3'd3;
    localparam logic [2:0] F_PZ   = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    typedef struct packed {
        logic [IW-1:0] i0;
        logic [IW-1:0] i1;
        logic [FW-1:0] f;
    } place_t;

    logic [2:0]                 state_reg, state_next;
    logic [hbs_pkg::KIND_W-1:0] kind_reg;
    logic [7:0]                 gx_reg, gz_reg;
    logic [31:0]                hin_reg, wx_reg, wz_reg;
    logic signed [57:0]         prod_reg;
    logic [31:0]                lx_reg, lz_reg;
    place_t                     px_reg, pz_reg;

    logic [NW-1:0]      gs_ext;
    logic [IW-1:0]      nm1;
    logic signed [32:0] mul_d;
    logic signed [57:0] prod_next;
    logic signed [32:0] wx33, wz33, ox33, oz33, limx, limz;
    logic               in_chunk;

    // Saturate the floored Q16.16 local coordinate to 32 bits
    function automatic logic [31:0] sat_local(input logic [57:0] p);
        logic [41:0] sh;
        sh = p[57:16];
        if ((&sh[41:31]) || !(|sh[41:31]))
            return sh[31:0];
        else if (sh[41])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

    function automatic place_t place(input logic [31:0] l, input logic [IW-1:0] lim);
        place_t p;
        logic   hi;
        hi = !l[31] && (l[31:16] > 16'(lim));
        if (l[31])
        begin
            p.i0 = '0;
            p.f  = '0;
        end
        else if (hi)
        begin
            p.i0 = lim;
            p.f  = FW'(17'h1_0000);
        end
        else
        begin
            p.i0 = l[16 +: IW];
            p.f  = FW'(l[15:0]);
        end
        p.i1 = (p.i0 == lim) ? lim : p.i0 + IW'(1);
        return p;
    endfunction

    function automatic logic [IW-1:0] clamp_grid(input logic [7:0] g, input logic [IW-1:0] lim);
        if (g[7])
            return '0;
        else if (g[IW-1:0] > lim)
            return lim;
        else
            return g[IW-1:0];
    endfunction

    function automatic logic off_grid(input logic [7:0] g, input logic [IW-1:0] lim);
        return g[7] || (g[IW-1:0] > lim);
    endfunction

    // Points in use, saturated to [2, MAX_RES], held as the last index
    assign gs_ext = NW'(cfg.grid_size);
    always_comb
    begin
        if (gs_ext < NW'(2))
            nm1 = IW'(1);
        else if (gs_ext > MAX_N)
            nm1 = MAX_IDX;
        else
            nm1 = IW'(gs_ext - NW'(1));
    end

    assign wx33 = {wx_reg[31], wx_reg};
    assign wz33 = {wz_reg[31], wz_reg};
    assign ox33 = {cfg.origin_x[31], cfg.origin_x};
    assign oz33 = {cfg.origin_z[31], cfg.origin_z};
    assign limx = ox33 + $signed({2'b00, cfg.chunk_extent});
    assign limz = oz33 + $signed({2'b00, cfg.chunk_extent});
    assign in_chunk = (wx33 >= ox33) && (wx33 <= limx) && (wz33 >= oz33) && (wz33 <= limz);

    // One multiplier, X offset first, then Z
    assign mul_d     = (state_reg == F_MX) ? (wx33 - ox33) : (wz33 - oz33);
    assign prod_next = mul_d * $signed({1'b0, cfg.inv_spacing});

    assign in_ready = (state_reg == F_IDLE) && !clearing;
    assign q_push   = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = (in_kind == hbs_pkg::KIND_SAMPLE) ? F_MX : F_PUSH;
            end
            F_MX:    state_next = F_MZ;
            F_MZ:    state_next = F_PX;
            F_PX:    state_next = F_PZ;
            F_PZ:    state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.kind     = kind_reg;
        q_cmd.wdata    = hin_reg;
        q_cmd.in_chunk = in_chunk;
        case (kind_reg)
            hbs_pkg::KIND_WRITE:
            begin
                q_cmd.x0     = gx_reg[IW-1:0];
                q_cmd.z0     = gz_reg[IW-1:0];
                q_cmd.status = off_grid(gx_reg, nm1) || off_grid(gz_reg, nm1);
            end
            hbs_pkg::KIND_READ:
            begin
                q_cmd.x0 = clamp_grid(gx_reg, nm1);
                q_cmd.z0 = clamp_grid(gz_reg, nm1);
            end
            hbs_pkg::KIND_SAMPLE:
            begin
                q_cmd.x0 = px_reg.i0;
                q_cmd.x1 = px_reg.i1;
                q_cmd.fx = px_reg.f;
                q_cmd.z0 = pz_reg.i0;
                q_cmd.z1 = pz_reg.i1;
                q_cmd.fz = pz_reg.f;
            end
            default:
            begin
                q_cmd.status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= in_kind;
            gx_reg   <= in_gx;
            gz_reg   <= in_gz;
            hin_reg  <= in_hin;
            wx_reg   <= in_wx;
            wz_reg   <= in_wz;
        end
        if (state_reg == F_MX || state_reg == F_MZ)
            prod_reg <= prod_next;
        if (state_reg == F_MZ)
            lx_reg <= sat_local(prod_reg);
        if (state_reg == F_PX)
        begin
            px_reg <= place(lx_reg, nm1);
            lz_reg <= sat_local(prod_reg);
        end
        if (state_reg == F_PZ)
            pz_reg <= place(lz_reg, nm1);
    end

endmodule

`default_nettype wire

@@ sv/hbs_queue.sv @@
// Two-entry request queue between the front and the back end.
// Depends on hbs_pkg for the request type.
`default_nettype none

module hbs_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hbs_pkg::hbs_cmd_t cmd_in,
    output logic                   full,
    input  wire logic              pop,
    output hbs_pkg::hbs_cmd_t      cmd_out,
    output logic                   empty
);

    hbs_pkg::hbs_cmd_t ent_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = ent_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

@@ sv/hbs_back.sv @@
// Back end: height store, neighbor fetch, bilinear blend and result register.
// Depends on hbs_pkg; drains hbs_queue.
`default_nettype none

module hbs_back #(
    parameter int MAX_RES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire hbs_pkg::hbs_cmd_t q_cmd,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            out_height,
    output logic                   out_inside,
    output logic                   out_status
);

    localparam int IW    = $clog2(MAX_RES);
    localparam int DEPTH = MAX_RES * MAX_RES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_S1    = 4'd3;
    localparam logic [3:0] ST_S2    = 4'd4;
    localparam logic [3:0] ST_S3    = 4'd5;
    localparam logic [3:0] ST_S4    = 4'd6;
    localparam logic [3:0] ST_S5    = 4'd7;
    localparam logic [3:0] ST_S6    = 4'd8;
    localparam logic [3:0] ST_S7    = 4'd9;

    logic [31:0] mem [DEPTH];

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg;
    hbs_pkg::hbs_cmd_t  cur_reg;
    logic [31:0]        rd_reg;
    logic [31:0]        a_reg, r0_reg, r1_reg;
    logic signed [50:0] prod_reg;
    logic               out_valid_reg;
    logic [31:0]        out_height_reg;
    logic               out_inside_reg, out_status_reg;

    logic               out_free;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [31:0]        mem_wdata;
    logic               load_out;
    logic [31:0]        out_h;
    logic               out_in, out_st;
    logic signed [32:0] mul_a;
    logic [16:0]        mul_b;
    logic signed [50:0] prod_next;

    function automatic logic [AW-1:0] addr_of(input logic [hbs_pkg::IDX_W-1:0] x,
                                              input logic [hbs_pkg::IDX_W-1:0] z);
        return AW'(z[IW-1:0]) * AW'(MAX_RES) + AW'(x[IW-1:0]);
    endfunction

    // Round half up: floor((p + 32768) / 65536), low 32 bits
    function automatic logic [31:0] rnd16(input logic [50:0] p);
        logic [50:0] t;
        t = p + 51'd32768;
        return t[47:16];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign prod_next = mul_a * $signed({1'b0, mul_b});

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = addr_of(q_cmd.x0, q_cmd.z0);
        mem_wdata  = q_cmd.wdata;
        load_out   = 1'b0;
        out_h      = '0;
        out_in     = cur_reg.in_chunk;
        out_st     = cur_reg.status;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.kind)
                        hbs_pkg::KIND_READ:
                        begin
                            q_pop      = 1'b1;
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        hbs_pkg::KIND_SAMPLE:
                        begin
                            q_pop      = 1'b1;
                            mem_re     = 1'b1;
                            state_next = ST_S1;
                        end
                        default:
                        begin
                            // write or unused kind: answer at once
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                mem_we   = (q_cmd.kind == hbs_pkg::KIND_WRITE) && !q_cmd.status;
                                load_out = 1'b1;
                                out_in   = q_cmd.in_chunk;
                                out_st   = q_cmd.status;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    out_h      = rd_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_S1:
            begin
                mem_re     = 1'b1;
                mem_addr   = addr_of(cur_reg.x1, cur_reg.z0);
                state_next = ST_S2;
            end
            ST_S2:
            begin
                mem_re     = 1'b1;
                mem_addr   = addr_of(cur_reg.x0, cur_reg.z1);
                mul_a      = $signed({rd_reg[31], rd_reg}) - $signed({a_reg[31], a_reg});
                mul_b      = cur_reg.fx;
                state_next = ST_S3;
            end
            ST_S3:
            begin
                mem_re     = 1'b1;
                mem_addr   = addr_of(cur_reg.x1, cur_reg.z1);
                state_next = ST_S4;
            end
            ST_S4:
            begin
                mul_a      = $signed({rd_reg[31], rd_reg}) - $signed({a_reg[31], a_reg});
                mul_b      = cur_reg.fx;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                state_next = ST_S6;
            end
            ST_S6:
            begin
                mul_a      = $signed({r1_reg[31], r1_reg}) - $signed({r0_reg[31], r0_reg});
                mul_b      = cur_reg.fz;
                state_next = ST_S7;
            end
            ST_S7:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    out_h      = r0_reg + rnd16(prod_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Single-port height store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        else if (mem_re)
            rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
        if (load_out)
        begin
            out_height_reg <= out_h;
            out_inside_reg <= out_in;
            out_status_reg <= out_st;
        end
        if (state_reg == ST_S2 || state_reg == ST_S4 || state_reg == ST_S6)
            prod_reg <= prod_next;
        if (state_reg == ST_S1 || state_reg == ST_S3)
            a_reg <= rd_reg;
        if (state_reg == ST_S3)
            r0_reg <= a_reg + rnd16(prod_reg);
        if (state_reg == ST_S5)
            r1_reg <= a_reg + rnd16(prod_reg);
    end

    assign out_valid  = out_valid_reg;
    assign out_height = out_height_reg;
    assign out_inside = out_inside_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

@@ sv/heightmap_bilinear_sampler.sv @@
// Heightmap bilinear sampler: a square grid of signed Q16.16 heights, up to MAX_RES points
// per side, that takes writes, clamped reads and bilinear samples at world X/Z positions.
// After reset the height store is swept to zero, one entry per cycle, over all MAX_RES*MAX_RES
// entries (4096 at the default); s_tready stays low during the sweep while the APB port
// still takes writes. A request then passes a front end (for a sample, one shared multiplier
// maps X then Z onto the grid) and a two-entry queue into a back end that owns the
// single-port store. For a sample the four neighbor heights come one per cycle from the store
// and the three blends share one multiplier. Front and back overlap, so the front can take
// a new request while the back end still works on an earlier one.
// Depends on hbs_pkg, hbs_front, hbs_queue, hbs_back and the defines header.
`default_nettype none

`include "heightmap_bilinear_sampler_defines.svh"

module heightmap_bilinear_sampler #(
    parameter int MAX_RES = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // APB configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hbs_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // request stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [111:0]               s_tdata,  // grid_x, grid_z, height_in, world_x, world_z
    input  wire logic [1:0]                 s_tuser,  // kind
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [31:0]                     m_tdata,  // height_out
    output logic [1:0]                      m_tuser   // inside_chunk, status
);

    hbs_pkg::hbs_cfg_t cfg_reg;
    logic [2:0]        outstanding_reg, outstanding_next;

    logic              cfg_wr;
    logic [2:0]        reg_idx;
    logic              clearing;
    logic              q_push, q_pop, q_full, q_empty;
    hbs_pkg::hbs_cmd_t q_in, q_out;
    logic              in_acc, out_acc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_z     <= '0;
            cfg_reg.chunk_extent <= 31'd4194304;
            cfg_reg.inv_spacing  <= 24'd65536;
            cfg_reg.grid_size    <= 7'd64;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                hbs_pkg::REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata;
                hbs_pkg::REG_ORIGIN_Z:     cfg_reg.origin_z     <= pwdata;
                hbs_pkg::REG_CHUNK_EXTENT: cfg_reg.chunk_extent <= pwdata[30:0];
                hbs_pkg::REG_INV_SPACING:  cfg_reg.inv_spacing  <= pwdata[23:0];
                hbs_pkg::REG_GRID_SIZE:    cfg_reg.grid_size    <= pwdata[6:0];
                default:                   cfg_reg.grid_size    <= cfg_reg.grid_size;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hbs_pkg::REG_ORIGIN_X:     prdata = cfg_reg.origin_x;
            hbs_pkg::REG_ORIGIN_Z:     prdata = cfg_reg.origin_z;
            hbs_pkg::REG_CHUNK_EXTENT: prdata = 32'(cfg_reg.chunk_extent);
            hbs_pkg::REG_INV_SPACING:  prdata = 32'(cfg_reg.inv_spacing);
            hbs_pkg::REG_GRID_SIZE:    prdata = 32'(cfg_reg.grid_size);
            default:                   prdata = '0;
        endcase
    end

    hbs_front #(
        .MAX_RES (MAX_RES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_gx    (s_tdata[7:0]),
        .in_gz    (s_tdata[15:8]),
        .in_hin   (s_tdata[47:16]),
        .in_wx    (s_tdata[79:48]),
        .in_wz    (s_tdata[111:80]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    hbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .cmd_out (q_out),
        .empty   (q_empty)
    );

    hbs_back #(
        .MAX_RES (MAX_RES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (q_out),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_height (m_tdata),
        .out_inside (m_tuser[0]),
        .out_status (m_tuser[1])
    );

    // Count requests accepted but not yet answered
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_acc && !out_acc)
            outstanding_next = outstanding_reg + 3'd1;
        else if (out_acc && !in_acc)
            outstanding_next = outstanding_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= 3'd0;
        else
            outstanding_reg <= outstanding_next;
    end

    `HBS_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, clearing, !s_tready, "request accepted during store clear")
    `HBS_ASSERT_NOW(a_queue_no_overflow, clk, rst_n, q_full, !q_push, "push into full queue")
    `HBS_ASSERT_NOW(a_result_has_request, clk, rst_n, m_tvalid, outstanding_reg != 3'd0, "result without request")
    `HBS_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, q_push && !q_pop, !q_empty, "queue empty after push")

endmodule

`default_nettype wire

@@ tb/heightmap_bilinear_sampler_tb.sv @@
// Self-checking testbench for heightmap_bilinear_sampler: writes, clamped reads and bilinear
// samples over several register settings, checked against an in-bench predictor.
// Depends on hbs_pkg and the heightmap_bilinear_sampler RTL.
module heightmap_bilinear_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RES = 64;
    localparam int DRAIN_CYCLES = 24;
    localparam int SEGMENT_ITEMS = 55;
    localparam longint Q16_ONE = 65536;
    localparam longint INT_MIN = -64'sd2147483648;
    localparam longint INT_MAX = 64'sd2147483647;
    localparam logic [hbs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [hbs_pkg::KIND_W-1:0] kind;
        logic signed [7:0]  grid_x;
        logic signed [7:0]  grid_z;
        logic signed [31:0] height_in;
        logic signed [31:0] world_x;
        logic signed [31:0] world_z;
    } height_request_t;

    typedef struct {
        logic [31:0] height;
        logic        in_chunk;
        logic        status;
    } height_result_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [hbs_pkg::CFG_AW-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           s_tvalid;
    logic           s_tready;
    logic [111:0]   s_tdata;   // grid_x, grid_z, height_in, world_x, world_z
    logic [1:0]     s_tuser;   // kind
    logic           m_tvalid;
    logic           m_tready;
    logic [31:0]    m_tdata;   // height_out
    logic [1:0]     m_tuser;   // inside_chunk, status

    // predictor state
    int             height_mirror [0:MAX_RES*MAX_RES-1];
    longint         cfg_origin_x = 0;
    longint         cfg_origin_z = 0;
    longint         cfg_chunk_extent = 4194304;
    longint         cfg_inv_spacing = 65536;
    logic [6:0]     cfg_grid_size = 7'd64;

    height_result_t pending_results [$];
    int             error_count = 0;
    int             results_seen = 0;
    int             settings_applied = 0;
    int             src_idle_pct = 0;
    int             sink_idle_pct = 0;

    heightmap_bilinear_sampler #(
        .MAX_RES (MAX_RES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint grid_points();
        return clamp_range(longint'(cfg_grid_size), 2, MAX_RES);
    endfunction

    function automatic longint height_at(longint x, longint z);
        return longint'(height_mirror[z * MAX_RES + x]);
    endfunction

    // Round half up: a + floor(((b - a) * f + 32768) / 65536)
    function automatic longint blend(longint a, longint b, longint f);
        return a + (((b - a) * f + 32768) >>> 16);
    endfunction

    function automatic void locate_on_grid(input longint w, input longint o, input longint n,
                                           output longint i0, output longint i1,
                                           output longint frac);
        longint pos_q;
        pos_q = clamp_range(((w - o) * cfg_inv_spacing) >>> 16, INT_MIN, INT_MAX);
        i0 = clamp_range(pos_q >>> 16, 0, n - 1);
        i1 = (i0 + 1 < n - 1) ? i0 + 1 : n - 1;
        frac = clamp_range(pos_q - i0 * Q16_ONE, 0, Q16_ONE);
    endfunction

    // Expected result of one request; an in-grid write also updates the mirror of the store.
    function automatic height_result_t predict_height_result(height_request_t r);
        height_result_t res;
        longint n, gx, gz, wx, wz, x0, x1, fx, z0, z1, fz, row0, row1, h;
        n = grid_points();
        gx = longint'(r.grid_x);
        gz = longint'(r.grid_z);
        wx = longint'(r.world_x);
        wz = longint'(r.world_z);
        h = 0;
        res.status = 1'b0;
        res.in_chunk = (wx >= cfg_origin_x) && (wx <= cfg_origin_x + cfg_chunk_extent) &&
                       (wz >= cfg_origin_z) && (wz <= cfg_origin_z + cfg_chunk_extent);
        case (r.kind)
            hbs_pkg::KIND_WRITE:
            begin
                if (gx < 0 || gx >= n || gz < 0 || gz >= n)
                    res.status = 1'b1;
                else
                    height_mirror[gz * MAX_RES + gx] = r.height_in;
            end
            hbs_pkg::KIND_READ:
            begin
                h = height_at(clamp_range(gx, 0, n - 1), clamp_range(gz, 0, n - 1));
            end
            hbs_pkg::KIND_SAMPLE:
            begin
                locate_on_grid(wx, cfg_origin_x, n, x0, x1, fx);
                locate_on_grid(wz, cfg_origin_z, n, z0, z1, fz);
                row0 = blend(height_at(x0, z0), height_at(x1, z0), fx);
                row1 = blend(height_at(x0, z1), height_at(x1, z1), fx);
                h = blend(row0, row1, fz);
            end
            default: ;
        endcase
        res.height = h[31:0];
        return res;
    endfunction

    function automatic height_request_t make_request(logic [hbs_pkg::KIND_W-1:0] kind,
                                                     logic signed [7:0] gx,
                                                     logic signed [7:0] gz,
                                                     logic [31:0] hin,
                                                     logic [31:0] wx,
                                                     logic [31:0] wz);
        height_request_t r;
        r.kind = kind;
        r.grid_x = gx;
        r.grid_z = gz;
        r.height_in = hin;
        r.world_x = wx;
        r.world_z = wz;
        return r;
    endfunction

    // World coordinate that lands on or just around the grid, or on a chunk edge.
    function automatic logic [31:0] world_on_grid(longint origin, longint n);
        longint pos_q, d, w;
        if ($urandom_range(9) == 0)
        begin
            if ($urandom_range(1))
                d = cfg_chunk_extent + longint'($urandom_range(0, 2)) - 1;
            else
                d = longint'($urandom_range(0, 1)) - 1;
        end
        else
        begin
            pos_q = longint'($urandom_range(0, 32'(n * 65536 + 65536))) - 32768;
            d = (cfg_inv_spacing == 0) ? pos_q : (pos_q * 65536) / cfg_inv_spacing;
        end
        w = clamp_range(origin + d, INT_MIN, INT_MAX);
        return w[31:0];
    endfunction

    function automatic height_request_t random_request();
        height_request_t r;
        int pick;
        longint n;
        n = grid_points();
        r = make_request(KIND_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom,
                         $urandom);
        pick = $urandom_range(99);
        if (pick < 90)
        begin
            r.world_x = world_on_grid(cfg_origin_x, n);
            r.world_z = world_on_grid(cfg_origin_z, n);
        end
        if ($urandom_range(1))
            r.height_in = {{12{r.height_in[19]}}, r.height_in[19:0]};
        if (pick < 35)
        begin
            r.kind = hbs_pkg::KIND_WRITE;
            if (pick < 30)
            begin
                r.grid_x = 8'($urandom_range(0, 32'(n - 1)));
                r.grid_z = 8'($urandom_range(0, 32'(n - 1)));
            end
        end
        else if (pick < 55)
        begin
            r.kind = hbs_pkg::KIND_READ;
            if (pick < 50)
            begin
                r.grid_x = 8'($urandom_range(0, 32'(n - 1)));
                r.grid_z = 8'($urandom_range(0, 32'(n - 1)));
            end
        end
        else if (pick < 96)
        begin
            r.kind = hbs_pkg::KIND_SAMPLE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Queue the expected result of an accepted request.
    task automatic expect_result(input height_result_t res);
        pending_results.insert(pending_results.size(), res);
    endtask

    // Entered and left at a falling edge.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            hbs_pkg::REG_ORIGIN_X:     cfg_origin_x = longint'(signed'(value));
            hbs_pkg::REG_ORIGIN_Z:     cfg_origin_z = longint'(signed'(value));
            hbs_pkg::REG_CHUNK_EXTENT: cfg_chunk_extent = longint'(value[30:0]);
            hbs_pkg::REG_INV_SPACING:  cfg_inv_spacing = longint'(value[23:0]);
            hbs_pkg::REG_GRID_SIZE:    cfg_grid_size = value[6:0];
            default: ;
        endcase
    endtask

    // Entered and left at a falling edge; valid stays high for a following request.
    task automatic send_request(input height_request_t r);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = r.kind;
        s_tdata = {r.world_z, r.world_x, r.height_in, r.grid_z, r.grid_x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expect_result(predict_height_result(r));
        @(negedge clk);
    endtask

    // Hold requests until every pending result is back and the pipeline is quiet.
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input int idx);
        logic [31:0] ox, oz;
        logic [30:0] ext;
        logic [23:0] inv;
        logic [6:0]  gsize;
        longint      n, span;
        int          pick;
        case (idx)
            0:
            begin
                ox = 32'h8000_0000;
                oz = 32'h7FFF_FFFF;
                ext = 31'h7FFF_FFFF;
                inv = 24'hFF_FFFF;
                gsize = 7'd127;
            end
            1:
            begin
                // zero spacing reciprocal pins every sample to the corner
                ox = 32'd0;
                oz = 32'd0;
                ext = 31'd0;
                inv = 24'd0;
                gsize = 7'd0;
            end
            2:
            begin
                ox = $urandom;
                oz = $urandom;
                ext = 31'($urandom);
                inv = 24'd1;
                gsize = 7'd1;
            end
            3:
            begin
                ox = -32'sd131072;
                oz = 32'd327680;
                ext = 31'd65536;
                inv = 24'd65536;
                gsize = 7'd2;
            end
            default:
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    gsize = 7'($urandom_range(2, MAX_RES));
                else if (pick < 95)
                    gsize = 7'($urandom_range(MAX_RES + 1, 127));
                else
                    gsize = 7'($urandom_range(0, 1));
                n = clamp_range(longint'(gsize), 2, MAX_RES);
                inv = 24'($urandom_range(4096, 262144));
                ox = $urandom;
                oz = $urandom;
                if ($urandom_range(3) != 0)
                    ox = {{3{ox[31]}}, ox[28:0]};
                if ($urandom_range(3) != 0)
                    oz = {{3{oz[31]}}, oz[28:0]};
                span = ((n - 1) * 64'sd4294967296) / longint'(inv);
                span = span + longint'($urandom_range(0, 131072)) - 65536;
                span = clamp_range(span, 0, INT_MAX);
                ext = span[30:0];
            end
        endcase
        apb_write(hbs_pkg::REG_ORIGIN_X, ox);
        apb_write(hbs_pkg::REG_ORIGIN_Z, oz);
        apb_write(hbs_pkg::REG_CHUNK_EXTENT, {1'b0, ext});
        apb_write(hbs_pkg::REG_INV_SPACING, {8'd0, inv});
        apb_write(hbs_pkg::REG_GRID_SIZE, {25'd0, gsize});
    endtask

    // Corners, out-of-range writes, clamped reads, saturating and edge samples and unused kinds at reset setup.
    task automatic test_directed();
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd0, 8'sd0, 32'h7FFF_FFFF,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd1, 8'sd0, 32'h8000_0000,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd0, 8'sd1, 32'hFFFD_0000,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd1, 8'sd1, 32'h0001_2345,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd63, 8'sd63, 32'h8000_0000,
                                  32'h003F_0000, 32'h003F_0000));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd62, 8'sd63, 32'h7FFF_FFFF,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd64, 8'sd0, 32'h5555_AAAA,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, -8'sd1, 8'sd5, 32'h1234_5678,
                                  32'hFFFF_FFFF, 32'd0));
        send_request(make_request(hbs_pkg::KIND_WRITE, 8'sd127, -8'sd128, 32'hFFFF_FFFF,
                                  32'd0, 32'h0040_0001));
        send_request(make_request(hbs_pkg::KIND_READ, 8'sd0, 8'sd0, 32'd0, 32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_READ, 8'sd1, 8'sd0, 32'd0, 32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_READ, -8'sd128, -8'sd128, 32'd0,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_READ, 8'sd127, 8'sd127, 32'd0,
                                  32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'd0, 32'd0));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h8000,
                                  32'h8000));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h8000,
                                  32'd0));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h0001_8000,
                                  32'h4000));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h8000_0000,
                                  32'h8000_0000));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h0040_0000,
                                  32'h0040_0000));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h0040_0001,
                                  32'd0));
        send_request(make_request(hbs_pkg::KIND_SAMPLE, 8'sd0, 8'sd0, 32'd0, 32'h003E_8000,
                                  32'h003F_0000));
        send_request(make_request(KIND_UNUSED, -8'sd1, -8'sd1, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(KIND_UNUSED, 8'sd3, 8'sd3, 32'h1111_1111,
                                  32'h0001_0000, 32'h0002_0000));
    endtask

    task automatic test_random_phase(input int src_idle, input int sink_idle,
                                     input int count, input bit pause_midway);
        int done;
        src_idle_pct = src_idle;
        sink_idle_pct = sink_idle;
        done = 0;
        while (done < count)
        begin
            wait_for_results();
            apply_setting(settings_applied);
            settings_applied++;
            repeat (SEGMENT_ITEMS)
            begin
                if (pause_midway && done == count / 2)
                    wait_for_results();
                send_request(random_request());
                done++;
            end
        end
    endtask

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin : check_results
        height_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result height %h flags %b",
                                          m_tdata, m_tuser));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.height)
                    report_mismatch($sformatf("result %0d height %h, predicted %h",
                                              results_seen, m_tdata, want.height));
                if (m_tuser[0] !== want.in_chunk)
                    report_mismatch($sformatf("result %0d inside_chunk %b, predicted %b",
                                              results_seen, m_tuser[0], want.in_chunk));
                if (m_tuser[1] !== want.status)
                    report_mismatch($sformatf("result %0d status %b, predicted %b",
                                              results_seen, m_tuser[1], want.status));
            end
            results_seen++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the block sweeps its store after reset; the first request waits on tready
        src_idle_pct = 20;
        sink_idle_pct = 82;
        test_directed();
        test_random_phase(20, 82, 330, 1'b1);
        test_random_phase(82, 20, 330, 1'b0);
        test_random_phase(0, 0, 330, 1'b0);
        wait_for_results();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/hbs_pkg.sv
sv/hbs_front.sv
sv/hbs_queue.sv
sv/hbs_back.sv
sv/heightmap_bilinear_sampler.sv
tb/heightmap_bilinear_sampler_tb.sv
